// ===== src/pbwfp_pkg.sv =====
// Package for the protobuf wire field parser: codes, record type, constants.
// No dependencies.
`default_nettype none
package pbwfp_pkg;
    localparam int POS_WIDTH_DEF = 32;
    localparam int FIFO_DEPTH = 4;

    localparam logic [2:0] PH_KEY  = 3'd0;
    localparam logic [2:0] PH_VAL  = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_DROP = 3'd4;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_VAR_CUT  = 3'd1;
    localparam logic [2:0] ERR_VAR_LONG = 3'd2;
    localparam logic [2:0] ERR_F64_CUT  = 3'd3;
    localparam logic [2:0] ERR_F32_CUT  = 3'd4;
    localparam logic [2:0] ERR_LEN_CUT  = 3'd5;
    localparam logic [2:0] ERR_BAD_WT   = 3'd6;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_F64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_F32    = 3'd5;

    localparam logic [3:0] MAX_VARINT_BYTES = 4'd10;

    typedef struct packed {
        logic [28:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] varint_value;
        logic [31:0] payload_offset;
        logic [31:0] payload_length;
        logic [31:0] field_start;
        logic [31:0] field_end;
        logic [2:0]  error_code;
        logic        message_end;
    } t_rec;
endpackage
`default_nettype wire

// ===== src/pbwfp_front.sv =====
// Front end: per-byte wire-format state machine; emits at most one record a beat.
// Depends on pbwfp_pkg.
`default_nettype none
module pbwfp_front
    import pbwfp_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_rec_valid,
    output t_rec            o_rec
);
    logic [2:0]           r_phase, n_phase;
    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic [3:0]           r_cnt, n_cnt;
    logic [63:0]          r_acc, n_acc;
    logic [28:0]          r_fnum, n_fnum;
    logic [2:0]           r_wt, n_wt;
    logic [POS_WIDTH-1:0] r_fstart, n_fstart;
    logic [POS_WIDTH-1:0] r_poff, n_poff;
    logic [POS_WIDTH-1:0] r_left, n_left;

    logic [POS_WIDTH-1:0] nxt;
    logic [63:0]          acc_in, v, shifted;
    logic [6:0]           sh;
    logic                 emit;
    logic [63:0]          e_val;
    logic [POS_WIDTH-1:0] e_off, e_len;
    logic [2:0]           e_err;
    logic [28:0]          key_fnum;
    logic [2:0]           key_wt;

    assign nxt     = r_pos + 1'b1;
    assign sh      = 7'(7 * r_cnt);
    assign shifted = {57'd0, i_data_byte[6:0]} << sh;

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_cnt = r_cnt; n_acc = r_acc;
        n_fnum = r_fnum; n_wt = r_wt; n_fstart = r_fstart; n_poff = r_poff;
        n_left = r_left;
        emit = 1'b0; e_val = '0; e_off = '0; e_len = '0; e_err = ERR_OK;
        acc_in = r_acc; v = '0;
        key_fnum = r_fnum; key_wt = r_wt;
        if (r_phase == PH_KEY || r_phase == PH_VAL || r_phase == PH_LEN) begin
            if (r_phase == PH_KEY && r_cnt == 4'd0) begin
                n_fstart = r_pos; n_fnum = '0; n_wt = '0; acc_in = '0;
                key_fnum = '0; key_wt = '0;
            end
            if (r_cnt >= MAX_VARINT_BYTES) begin
                n_acc = acc_in;
                emit = 1'b1; e_err = ERR_VAR_LONG; n_phase = PH_DROP;
            end else begin
                v = acc_in | shifted;
                n_acc = v;
                n_cnt = r_cnt + 4'd1;
                if (i_data_byte[7]) begin
                    if (i_last_byte) begin
                        emit = 1'b1; e_err = ERR_VAR_CUT; n_phase = PH_DROP;
                    end
                end else begin
                    n_acc = '0; n_cnt = '0;
                    if (r_phase == PH_KEY) begin
                        key_fnum = v[31:3]; key_wt = v[2:0];
                        n_fnum = key_fnum; n_wt = key_wt;
                        case (key_wt)
                            WT_VARINT, WT_LEN: begin
                                if (i_last_byte) begin
                                    emit = 1'b1; e_err = ERR_VAR_CUT; n_phase = PH_DROP;
                                end else begin
                                    n_phase = (key_wt == WT_VARINT) ? PH_VAL : PH_LEN;
                                end
                            end
                            WT_F64, WT_F32: begin
                                if (i_last_byte) begin
                                    emit = 1'b1;
                                    e_err = (key_wt == WT_F64) ? ERR_F64_CUT : ERR_F32_CUT;
                                    n_phase = PH_DROP;
                                end else begin
                                    n_left = (key_wt == WT_F64) ? POS_WIDTH'(8) : POS_WIDTH'(4);
                                    n_poff = nxt; n_phase = PH_SKIP;
                                end
                            end
                            default: begin
                                emit = 1'b1; e_err = ERR_BAD_WT; n_phase = PH_DROP;
                            end
                        endcase
                    end else if (r_phase == PH_VAL) begin
                        emit = 1'b1; e_val = v; n_phase = PH_KEY;
                    end else begin
                        if (POS_WIDTH < 64 && (v >> POS_WIDTH) != 64'd0) begin
                            emit = 1'b1; e_err = ERR_LEN_CUT; n_phase = PH_DROP;
                        end else if (v == 64'd0) begin
                            emit = 1'b1; e_off = nxt; n_phase = PH_KEY;
                        end else if (i_last_byte) begin
                            emit = 1'b1; e_err = ERR_LEN_CUT; n_phase = PH_DROP;
                        end else begin
                            n_left = v[POS_WIDTH-1:0]; n_poff = nxt; n_phase = PH_SKIP;
                        end
                    end
                end
            end
        end else if (r_phase == PH_SKIP) begin
            if (r_left <= POS_WIDTH'(1)) begin
                n_left = '0; emit = 1'b1; e_off = r_poff; e_len = nxt - r_poff;
                n_phase = PH_KEY;
            end else begin
                n_left = r_left - 1'b1;
                if (i_last_byte) begin
                    emit = 1'b1;
                    e_err = (r_wt == WT_F64) ? ERR_F64_CUT :
                            (r_wt == WT_F32) ? ERR_F32_CUT : ERR_LEN_CUT;
                    n_phase = PH_DROP;
                end
            end
        end
        if (i_last_byte) begin
            n_phase = PH_KEY; n_pos = '0; n_cnt = '0; n_acc = '0; n_left = '0;
        end else begin
            n_pos = nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_KEY; r_pos <= '0; r_cnt <= '0; r_acc <= '0;
            r_fnum <= '0; r_wt <= '0; r_fstart <= '0; r_poff <= '0; r_left <= '0;
            o_rec_valid <= 1'b0;
        end else begin
            o_rec_valid <= i_valid && emit;
            if (i_valid) begin
                r_phase <= n_phase; r_pos <= n_pos; r_cnt <= n_cnt; r_acc <= n_acc;
                r_fnum <= n_fnum; r_wt <= n_wt; r_fstart <= n_fstart;
                r_poff <= n_poff; r_left <= n_left;
            end
        end
    end

    // record register; held fields taken after this byte's key update
    always_ff @(posedge i_clk) begin
        if (i_valid && emit) begin
            o_rec.field_number   <= key_fnum;
            o_rec.wire_type      <= key_wt;
            o_rec.varint_value   <= e_val;
            o_rec.payload_offset <= 32'(e_off);
            o_rec.payload_length <= 32'(e_len);
            o_rec.field_start    <= 32'(n_fstart);
            o_rec.field_end      <= 32'(nxt);
            o_rec.error_code     <= e_err;
            o_rec.message_end    <= i_last_byte;
        end
    end
endmodule
`default_nettype wire

// ===== src/pbwfp_fifo.sv =====
// Record queue between the decoder and the result port.
// Depends on pbwfp_pkg.
`default_nettype none
module pbwfp_fifo
    import pbwfp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_rec      i_rec,
    input  wire logic i_pop,
    output logic      o_empty,
    output logic [$clog2(FIFO_DEPTH+1)-1:0] o_count,
    output t_rec      o_rec
);
    localparam int AW = $clog2(FIFO_DEPTH);
    t_rec r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [$clog2(FIFO_DEPTH+1)-1:0] r_cnt;
    logic do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (i_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_rec;
    end
endmodule
`default_nettype wire

// ===== src/protobuf_wire_field_parser.sv =====
// Protobuf wire field parser, top level: byte decoder front end plus record queue.
// Depends on pbwfp_pkg, pbwfp_front, pbwfp_fifo.
`default_nettype none
// Takes one message byte per clock (push/full) and produces one record per finished
// or failed field (empty/pop). A byte is decoded in the cycle it is accepted; its
// record is registered in the front end, then written into a four-entry queue whose
// head drives the result ports, and empty falls once the record is in that queue.
// Sustained rate is one byte per cycle; full rises only when the queue, counting the
// record still in the register, could not absorb one more, so input stalls only
// while the result side is held back. Offsets count modulo 2^POS_WIDTH and restart
// at zero after each final byte; after an error the rest of the message is dropped.
module protobuf_wire_field_parser
    import pbwfp_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [28:0]      o_field_number,
    output logic [2:0]       o_wire_type,
    output logic [63:0]      o_varint_value,
    output logic [31:0]      o_payload_offset,
    output logic [31:0]      o_payload_length,
    output logic [31:0]      o_field_start,
    output logic [31:0]      o_field_end,
    output logic [2:0]       o_error_code,
    output logic             o_message_end
);
    logic rec_valid;
    t_rec rec, head;
    logic [$clog2(FIFO_DEPTH+1)-1:0] cnt;
    logic accept;

    // count + pending register must leave room for one more beat
    assign full   = (32'(cnt) + (rec_valid ? 32'd1 : 32'd0)) >= 32'(FIFO_DEPTH);
    assign accept = push && !full;

    pbwfp_front #(.POS_WIDTH(POS_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept),
        .i_data_byte(i_data_byte), .i_last_byte(i_last_byte),
        .o_rec_valid(rec_valid), .o_rec(rec)
    );

    pbwfp_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(rec_valid), .i_rec(rec),
        .i_pop(pop), .o_empty(empty), .o_count(cnt), .o_rec(head)
    );

    assign o_field_number   = head.field_number;
    assign o_wire_type      = head.wire_type;
    assign o_varint_value   = head.varint_value;
    assign o_payload_offset = head.payload_offset;
    assign o_payload_length = head.payload_length;
    assign o_field_start    = head.field_start;
    assign o_field_end      = head.field_end;
    assign o_error_code     = head.error_code;
    assign o_message_end    = head.message_end;
endmodule
`default_nettype wire

// ===== src/pbwfp_checker.sv =====
// Port-level checker for the protobuf wire field parser, bound to the top level.
// Depends on pbwfp_pkg.
`default_nettype none
module pbwfp_checker
    import pbwfp_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [2:0] o_error_code,
    input wire logic [63:0] o_varint_value,
    input wire logic [31:0] o_payload_length,
    input wire logic [31:0] o_payload_offset
);
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_error_code <= ERR_BAD_WT) else $error("bad error code");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_code != ERR_OK) |->
        (o_varint_value == 64'd0 && o_payload_length == 32'd0 && o_payload_offset == 32'd0))
        else $error("error record carries data");
    // a beat accepted in the previous cycle may still be in the record register
    a_empty_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !(push && !full) && !$past(push && !full)) |=> empty)
        else $error("record without byte");
    a_hold_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty) else $error("record lost while held");
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full)) else $error("not empty after reset");
endmodule

bind protobuf_wire_field_parser pbwfp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .empty(empty),
    .pop(pop), .o_error_code(o_error_code), .o_varint_value(o_varint_value),
    .o_payload_length(o_payload_length), .o_payload_offset(o_payload_offset)
);
`default_nettype wire

// ===== dv/tb_protobuf_wire_field_parser.sv =====
// Testbench for protobuf_wire_field_parser: directed and random protobuf byte streams,
// checked record by record against an in-bench wire-format decoder.
// Depends on pbwfp_pkg and the parser RTL.
module tb_protobuf_wire_field_parser;
    import pbwfp_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        empty;
    logic        pop;
    logic [28:0] o_field_number;
    logic [2:0]  o_wire_type;
    logic [63:0] o_varint_value;
    logic [31:0] o_payload_offset;
    logic [31:0] o_payload_length;
    logic [31:0] o_field_start;
    logic [31:0] o_field_end;
    logic [2:0]  o_error_code;
    logic        o_message_end;

    protobuf_wire_field_parser u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_data_byte(i_data_byte), .i_last_byte(i_last_byte),
        .empty(empty), .pop(pop),
        .o_field_number(o_field_number), .o_wire_type(o_wire_type),
        .o_varint_value(o_varint_value), .o_payload_offset(o_payload_offset),
        .o_payload_length(o_payload_length), .o_field_start(o_field_start),
        .o_field_end(o_field_end), .o_error_code(o_error_code),
        .o_message_end(o_message_end)
    );

    // Decoder state, mirrors the block's
    logic [2:0]  dec_phase;
    logic [31:0] dec_pos;
    logic [3:0]  dec_vcount;
    logic [63:0] dec_acc;
    logic [28:0] dec_fnum;
    logic [2:0]  dec_wt;
    logic [31:0] dec_fstart;
    logic [31:0] dec_poff;
    logic [31:0] dec_left;

    t_rec expected_recs[$];
    int   fail_count;
    int   n_sent;         // bytes accepted so far
    bit   send_idle_en;   // random gaps on the byte side
    bit   pop_idle_en;    // random stalls on the record side
    int   pop_hold;       // cycles of forced hold-off on the record side

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #20000000;
        $display("tb_protobuf_wire_field_parser failed");
        $finish;
    end

    task automatic record_push(input logic [2:0] err, input logic [63:0] val,
                               input logic [31:0] off, input logic [31:0] len,
                               input logic [31:0] fend, input logic last);
        t_rec r;
        r.field_number   = dec_fnum;
        r.wire_type      = dec_wt;
        r.varint_value   = val;
        r.payload_offset = off;
        r.payload_length = len;
        r.field_start    = dec_fstart;
        r.field_end      = fend;
        r.error_code     = err;
        r.message_end    = last;
        expected_recs = {expected_recs, r};
    endtask

    // Advance the decoder by one accepted byte; queue the record it produces, if any.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [31:0] nxt;
        logic [63:0] v;
        nxt = dec_pos + 32'd1;
        if (dec_phase == PH_KEY || dec_phase == PH_VAL || dec_phase == PH_LEN) begin
            if (dec_phase == PH_KEY && dec_vcount == 0) begin
                dec_fstart = dec_pos;
                dec_fnum   = '0;
                dec_wt     = '0;
                dec_acc    = '0;
            end
            if (dec_vcount >= MAX_VARINT_BYTES) begin
                record_push(ERR_VAR_LONG, '0, '0, '0, nxt, last);
                dec_phase = PH_DROP;
            end else begin
                dec_acc = dec_acc | (64'(b[6:0]) << (7 * dec_vcount));
                dec_vcount = dec_vcount + 4'd1;
                if (b[7]) begin
                    if (last) begin
                        record_push(ERR_VAR_CUT, '0, '0, '0, nxt, last);
                        dec_phase = PH_DROP;
                    end
                end else begin
                    v = dec_acc;
                    dec_acc = '0;
                    dec_vcount = '0;
                    if (dec_phase == PH_KEY) begin
                        dec_fnum = v[31:3];
                        dec_wt   = v[2:0];
                        if (dec_wt == WT_VARINT || dec_wt == WT_LEN) begin
                            if (last) begin
                                record_push(ERR_VAR_CUT, '0, '0, '0, nxt, last);
                                dec_phase = PH_DROP;
                            end else begin
                                dec_phase = (dec_wt == WT_VARINT) ? PH_VAL : PH_LEN;
                            end
                        end else if (dec_wt == WT_F64 || dec_wt == WT_F32) begin
                            if (last) begin
                                record_push((dec_wt == WT_F64) ? ERR_F64_CUT : ERR_F32_CUT,
                                            '0, '0, '0, nxt, last);
                                dec_phase = PH_DROP;
                            end else begin
                                dec_left  = (dec_wt == WT_F64) ? 32'd8 : 32'd4;
                                dec_poff  = nxt;
                                dec_phase = PH_SKIP;
                            end
                        end else begin
                            record_push(ERR_BAD_WT, '0, '0, '0, nxt, last);
                            dec_phase = PH_DROP;
                        end
                    end else if (dec_phase == PH_VAL) begin
                        record_push(ERR_OK, v, '0, '0, nxt, last);
                        dec_phase = PH_KEY;
                    end else begin
                        if (v > 64'hFFFF_FFFF) begin
                            record_push(ERR_LEN_CUT, '0, '0, '0, nxt, last);
                            dec_phase = PH_DROP;
                        end else if (v == 0) begin
                            record_push(ERR_OK, '0, nxt, '0, nxt, last);
                            dec_phase = PH_KEY;
                        end else if (last) begin
                            record_push(ERR_LEN_CUT, '0, '0, '0, nxt, last);
                            dec_phase = PH_DROP;
                        end else begin
                            dec_left  = v[31:0];
                            dec_poff  = nxt;
                            dec_phase = PH_SKIP;
                        end
                    end
                end
            end
        end else if (dec_phase == PH_SKIP) begin
            if (dec_left <= 1) begin
                dec_left = '0;
                record_push(ERR_OK, '0, dec_poff, nxt - dec_poff, nxt, last);
                dec_phase = PH_KEY;
            end else begin
                dec_left = dec_left - 32'd1;
                if (last) begin
                    record_push((dec_wt == WT_F64) ? ERR_F64_CUT :
                                (dec_wt == WT_F32) ? ERR_F32_CUT : ERR_LEN_CUT,
                                '0, '0, '0, nxt, last);
                    dec_phase = PH_DROP;
                end
            end
        end
        if (last) begin
            dec_phase  = PH_KEY;
            dec_pos    = '0;
            dec_vcount = '0;
            dec_acc    = '0;
            dec_left   = '0;
        end else begin
            dec_pos = nxt;
        end
    endtask

    // Offer one byte, wait for the beat, update the decoder.
    // push stays high on return so the next byte can follow back to back.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (send_idle_en && $urandom_range(99) < 15) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decode_byte(b, last);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_varint(input logic [63:0] v, input logic last);
        do begin
            send_byte({(v >> 7) != 0, v[6:0]}, last && ((v >> 7) == 0));
            v = v >> 7;
        end while (v != 0);
    endtask

    task automatic send_key(input logic [28:0] fnum, input logic [2:0] wt, input logic last);
        send_varint({32'd0, fnum, wt}, last);
    endtask

    // One well-formed field of the given type, random content; optionally the message's last field.
    task automatic send_field(input logic [2:0] wt, input bit end_msg);
        logic [63:0] v;
        int n;
        case ($urandom_range(3))
            0: v = 64'($urandom_range(15));
            1: v = 64'($urandom);
            2: v = {$urandom, $urandom};
            default: v = 64'($urandom_range(127));
        endcase
        send_key(29'($urandom_range(3) == 0 ? $urandom : $urandom_range(40)), wt, 1'b0);
        if (wt == WT_VARINT) begin
            send_varint(v, end_msg);
        end else if (wt == WT_LEN) begin
            n = $urandom_range(9);
            send_varint(64'(n), end_msg && n == 0);
            for (int i = 0; i < n; i++) send_byte(8'($urandom), end_msg && i == n - 1);
        end else begin
            n = (wt == WT_F64) ? 8 : 4;
            for (int i = 0; i < n; i++) send_byte(8'($urandom), end_msg && i == n - 1);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_recs.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Record side: stall at random or during a forced hold-off; check on each beat.
    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else begin
            pop <= !(pop_idle_en && $urandom_range(99) < 15);
        end
    end

    always @(posedge i_clk) begin
        t_rec e;
        if (i_rst_n && pop && !empty) begin
            if (expected_recs.size() == 0) begin
                $error("record with nothing expected: field_start %0d", o_field_start);
                fail_count++;
            end else begin
                e = expected_recs.pop_front();
                if (o_field_number !== e.field_number) begin
                    $error("field_number exp %0h got %0h", e.field_number, o_field_number);
                    fail_count++;
                end
                if (o_wire_type !== e.wire_type) begin
                    $error("wire_type exp %0d got %0d", e.wire_type, o_wire_type);
                    fail_count++;
                end
                if (o_varint_value !== e.varint_value) begin
                    $error("varint_value exp %0h got %0h", e.varint_value, o_varint_value);
                    fail_count++;
                end
                if (o_payload_offset !== e.payload_offset) begin
                    $error("payload_offset exp %0d got %0d", e.payload_offset,
                           o_payload_offset);
                    fail_count++;
                end
                if (o_payload_length !== e.payload_length) begin
                    $error("payload_length exp %0d got %0d", e.payload_length,
                           o_payload_length);
                    fail_count++;
                end
                if (o_field_start !== e.field_start) begin
                    $error("field_start exp %0d got %0d", e.field_start, o_field_start);
                    fail_count++;
                end
                if (o_field_end !== e.field_end) begin
                    $error("field_end exp %0d got %0d", e.field_end, o_field_end);
                    fail_count++;
                end
                if (o_error_code !== e.error_code) begin
                    $error("error_code exp %0d got %0d", e.error_code, o_error_code);
                    fail_count++;
                end
                if (o_message_end !== e.message_end) begin
                    $error("message_end exp %0d got %0d", e.message_end, o_message_end);
                    fail_count++;
                end
            end
        end
    end

    // Good fields of every type, extremes of values and keys
    task automatic test_good_fields();
        send_key(29'd1, WT_VARINT, 1'b0);  send_varint(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_key(29'h1FFF_FFFF, WT_VARINT, 1'b0); send_varint(64'd0, 1'b0);
        send_key(29'd2, WT_F64, 1'b0);
        for (int i = 0; i < 8; i++) send_byte(8'hFF, 1'b0);
        send_key(29'd3, WT_F32, 1'b0);
        for (int i = 0; i < 4; i++) send_byte(8'h00, 1'b0);
        send_key(29'd4, WT_LEN, 1'b0); send_varint(64'd0, 1'b0);  // zero length
        send_key(29'd5, WT_LEN, 1'b0); send_varint(64'd2, 1'b0);
        send_byte(8'hAA, 1'b0); send_byte(8'h55, 1'b1);
        wait_drained();
    endtask

    // Every error kind and the final-byte special cases
    task automatic test_errors();
        // wide key: bits above 31 dropped
        send_varint(64'hF_FFFF_FFF8, 1'b0); send_varint(64'd7, 1'b1);
        for (int i = 0; i < 11; i++) send_byte(8'h80, 1'b0);   // overlong
        send_byte(8'h01, 1'b1);
        send_byte(8'h8F, 1'b1);                                // key cut
        send_key(29'd1, WT_VARINT, 1'b1);
        send_key(29'd1, WT_LEN, 1'b1);
        send_key(29'd1, WT_F64, 1'b1);
        send_key(29'd1, WT_F32, 1'b1);
        send_key(29'd1, 3'd3, 1'b0); send_byte(8'h00, 1'b1);  // bad type then dropped
        send_key(29'd1, 3'd4, 1'b1);
        send_key(29'd1, 3'd6, 1'b1);
        send_key(29'd1, 3'd7, 1'b1);
        send_key(29'd1, WT_LEN, 1'b0); send_varint(64'h1_0000_0000, 1'b1);
        send_key(29'd1, WT_LEN, 1'b0); send_varint(64'd3, 1'b1);
        send_key(29'd1, WT_LEN, 1'b0); send_varint(64'd3, 1'b0); send_byte(8'h1, 1'b1);
        send_key(29'd1, WT_F64, 1'b0); send_byte(8'h1, 1'b1);
        send_key(29'd1, WT_F32, 1'b0); send_byte(8'h1, 1'b1);
        send_key(29'd1, WT_VARINT, 1'b0); send_byte(8'hFF, 1'b1);
        wait_drained();
    endtask

    // Hold the record side off long enough that full rises
    task automatic test_backpressure();
        pop_hold = 60;
        for (int i = 0; i < 30; i++) send_field(WT_VARINT, i == 29);
        wait_drained();
    endtask

    task automatic test_random_messages(input int n_bytes);
        int sent;
        int base;
        int nf;
        logic [2:0] wt;
        base = n_sent;
        sent = 0;
        while (sent < n_bytes) begin
            if (sent > n_bytes / 3 && sent < n_bytes / 2) begin
                send_idle_en = 0; pop_idle_en = 0;   // no-gap stretch
            end else begin
                send_idle_en = 1; pop_idle_en = 1;
            end
            if ($urandom_range(9) == 0) begin
                // noise message
                nf = $urandom_range(1, 12);
                for (int i = 0; i < nf; i++) send_byte(8'($urandom), i == nf - 1);
            end else begin
                nf = $urandom_range(1, 5);
                for (int i = 0; i < nf; i++) begin
                    case ($urandom_range(3))
                        0: wt = WT_VARINT;
                        1: wt = WT_F64;
                        2: wt = WT_LEN;
                        default: wt = WT_F32;
                    endcase
                    if (i == nf - 1 && $urandom_range(7) == 0) begin
                        // cut the message short right after a key
                        send_key(29'($urandom_range(30)), wt, 1'b1);
                    end else begin
                        send_field(wt, i == nf - 1);
                    end
                end
            end
            if ($urandom_range(40) == 0) wait_drained();   // sender pause
            sent = n_sent - base;
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        fail_count = 0;
        n_sent = 0;
        pop_hold = 0;
        send_idle_en = 1;
        pop_idle_en = 1;
        dec_phase = PH_KEY; dec_pos = '0; dec_vcount = '0; dec_acc = '0;
        dec_fnum = '0; dec_wt = '0; dec_fstart = '0; dec_poff = '0; dec_left = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_good_fields();
        test_errors();
        test_backpressure();
        test_random_messages(1600);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && expected_recs.size() == 0) begin
            $display("tb_protobuf_wire_field_parser passed");
        end else begin
            $display("tb_protobuf_wire_field_parser failed");
        end
        $finish;
    end
endmodule
